// File: rtl/wrd_pkg.sv
`default_nettype none

package wrd_pkg;

    // History window depth and the width of an index into it
    localparam int HISTORY_DEPTH = 32;
    localparam int IDX_W         = $clog2(HISTORY_DEPTH);

    // Byte widths and stream codes
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 3;
    localparam logic [BYTE_W-1:0] LITERAL_CODE = 8'hFF;

    // Control that every history cell sees in a cycle
    typedef struct packed {
        logic shift;   // take the neighbor's byte
        logic clear;   // drop the held byte to zero (wins over shift)
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/wrd_cell.sv
`default_nettype none

module wrd_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire wrd_pkg::cell_ctl_t           ctl,
    input  wire logic [wrd_pkg::BYTE_W-1:0]   d_in,
    output logic      [wrd_pkg::BYTE_W-1:0]   q
);

    logic [wrd_pkg::BYTE_W-1:0] byte_reg;
    logic [wrd_pkg::BYTE_W-1:0] byte_next;

    // Clear wins; otherwise advance from the neighbor or hold
    always_comb
    begin
        if (ctl.clear)
        begin
            byte_next = '0;
        end
        else if (ctl.shift)
        begin
            byte_next = d_in;
        end
        else
        begin
            byte_next = byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign q = byte_reg;

endmodule

`default_nettype wire

// File: rtl/window_repeat_decoder.sv
`default_nettype none

// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tdata[7:0] = in_byte, s_tlast = in_last
// m_*       out  m_tvalid/m_tready    m_tdata[7:0] = out_byte, m_tlast = out_last
//
// A copy code emits (code & 7) + 1 output bytes, 1 to 8, one per cycle while
// the output is not stalled; a literal after its marker emits one byte.
// The next item is taken in the cycle that emits the last byte of the current one.
// The copy loop is the 32-cell shift chain: one byte shifts in per cycle
// while not stalled; the source cell is a fixed tap for the whole copy.
// Reset (rst_n low, asynchronous) zeroes every cell and all flags and counts.
// A stall on m_tready holds the output register and freezes the copy.

module window_repeat_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] in_byte
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,    // [7:0] out_byte
    output logic            m_tlast
);

    localparam int DEPTH = wrd_pkg::HISTORY_DEPTH;
    localparam int IW    = wrd_pkg::IDX_W;
    localparam int BW    = wrd_pkg::BYTE_W;
    localparam int CW    = wrd_pkg::COUNT_W;

    // Item control
    logic          busy_reg,     busy_next;
    logic          lit_mode_reg, lit_mode_next;
    logic          pending_reg,  pending_next;
    logic          last_reg,     last_next;
    logic [CW-1:0] cnt_reg,      cnt_next;
    logic [IW-1:0] tap_reg,      tap_next;
    logic [BW-1:0] lit_reg,      lit_next;

    // Output register
    logic          out_valid_reg, out_valid_next;
    logic [BW-1:0] out_data_reg,  out_data_next;
    logic          out_last_reg,  out_last_next;

    logic          emit;
    logic          final_emit;
    logic          accept;
    logic          is_marker;
    logic [BW-1:0] tap_byte;
    logic [BW-1:0] emit_byte;

    wrd_pkg::cell_ctl_t cell_ctl;
    logic [BW-1:0]      cell_q [DEPTH];

    // Emit when a byte is due and the output register is free
    assign emit       = busy_reg && (!out_valid_reg || m_tready);
    assign final_emit = emit && (cnt_reg == '0);
    assign s_tready   = !busy_reg || final_emit;
    assign accept     = s_tvalid && s_tready;
    assign is_marker  = !pending_reg && (s_tdata == wrd_pkg::LITERAL_CODE);

    assign tap_byte  = cell_q[tap_reg];
    assign emit_byte = lit_mode_reg ? lit_reg : tap_byte;

    // Shift on every emitted byte; clear when a chunk ends
    always_comb
    begin
        cell_ctl.shift = emit;
        cell_ctl.clear = (final_emit && last_reg) || (accept && is_marker && s_tlast);
    end

    // History chain: cell 0 holds the newest byte
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [BW-1:0] d_in;
            if (gi == 0)
            begin : g_head
                assign d_in = emit_byte;
            end
            else
            begin : g_body
                assign d_in = cell_q[gi-1];
            end
            wrd_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (cell_ctl),
                .d_in  (d_in),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    // Item sequencing
    always_comb
    begin
        busy_next     = busy_reg;
        lit_mode_next = lit_mode_reg;
        pending_next  = pending_reg;
        last_next     = last_reg;
        cnt_next      = cnt_reg;
        tap_next      = tap_reg;
        lit_next      = lit_reg;

        if (final_emit)
        begin
            busy_next = 1'b0;
        end
        else if (emit)
        begin
            cnt_next = cnt_reg - 1'b1;
        end

        if (accept)
        begin
            last_next = s_tlast;
            if (pending_reg)
            begin
                busy_next     = 1'b1;
                lit_mode_next = 1'b1;
                pending_next  = 1'b0;
                cnt_next      = '0;
                lit_next      = s_tdata;
            end
            else if (is_marker)
            begin
                busy_next    = 1'b0;
                pending_next = !s_tlast;
            end
            else
            begin
                busy_next     = 1'b1;
                lit_mode_next = 1'b0;
                cnt_next      = s_tdata[CW-1:0];
                // distance 32 - (code >> 3) is cell index 31 - (code >> 3)
                tap_next      = ~s_tdata[BW-1:CW];
            end
        end
    end

    // Output register: load on emit, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit_byte;
            out_last_next  = final_emit && last_reg;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            lit_mode_reg  <= 1'b0;
            pending_reg   <= 1'b0;
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            lit_mode_reg  <= lit_mode_next;
            pending_reg   <= pending_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tap_reg       <= tap_next;
        lit_reg       <= lit_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // An item enters mid-copy only on the copy's final byte
    a_accept_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && busy_reg) |-> final_emit)
        else $error("item accepted while a copy still has bytes left");

    // A literal emits exactly one byte
    a_literal_single: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && lit_mode_reg) |-> (cnt_reg == '0))
        else $error("literal item with a nonzero byte count");

    // An armed literal never overlaps a running item
    a_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> !busy_reg)
        else $error("literal armed while an item is running");

    // The newest and oldest history cells read zero right after a chunk ends
    a_clear_window: assert property (@(posedge clk) disable iff (!rst_n)
        cell_ctl.clear |=> ((cell_q[0] == '0) && (cell_q[DEPTH-1] == '0)))
        else $error("history not cleared after end of chunk");

endmodule

`default_nettype wire
